// ----- rtl/rpx_pkg.sv -----
// Shared constants and the arctangent table of the point rotation pipeline.
package rpx_pkg;

	localparam int COORD_WIDTH_DEF  = 32;
	localparam int ANGLE_WIDTH_DEF  = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int PHASE_W   = 32;
	localparam int TRIG_W    = 32;
	localparam int FRAC_W    = 30;
	localparam int ATAN_SIZE = 32;

	localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 32'sd652032874;

	localparam logic [PHASE_W-1:0] ATAN_TAB [ATAN_SIZE] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

endpackage

// ----- rtl/rpx_if.sv -----
// Handshake channels for points in and rotated points out.
interface rpx_point_if #(
	parameter int COORD_WIDTH = rpx_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH = rpx_pkg::ANGLE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] coord_x;
	logic signed [COORD_WIDTH-1:0] coord_y;
	logic signed [COORD_WIDTH-1:0] coord_z;
	logic signed [ANGLE_WIDTH-1:0] turn_angle;

	modport source (output valid, coord_x, coord_y, coord_z, turn_angle, input ready);
	modport sink (input valid, coord_x, coord_y, coord_z, turn_angle, output ready);
endinterface

interface rpx_result_if #(
	parameter int COORD_WIDTH = rpx_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] rotated_x;
	logic signed [COORD_WIDTH-1:0] rotated_y;
	logic signed [COORD_WIDTH-1:0] rotated_z;

	modport source (output valid, rotated_x, rotated_y, rotated_z, input ready);
	modport sink (input valid, rotated_x, rotated_y, rotated_z, output ready);
endinterface

// ----- rtl/rotate_point_about_x_axis.sv -----
// Channel  Dir  Handshake     Payload
// point    in   valid/ready   coord_x, coord_y, coord_z, turn_angle
// result   out  valid/ready   rotated_x, rotated_y, rotated_z
//
// One point enters per cycle unless an output stall backs up to the input; the stages are
// input register, one stage per CORDIC iteration, sign fix, multiply, round and saturate.
// Reset clears only the stage valid bits.
// A stall at the output holds only the full stages behind it; empty stages keep filling.
module rotate_point_about_x_axis #(
	parameter int COORD_WIDTH  = rpx_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH  = rpx_pkg::ANGLE_WIDTH_DEF,
	parameter int CORDIC_STEPS = rpx_pkg::CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rpx_point_if.sink   point,
	rpx_result_if.source result
);

	localparam int NS      = CORDIC_STEPS + 4;
	localparam int PASS_W  = 3 * COORD_WIDTH + 1;
	localparam int PROD_W  = COORD_WIDTH + rpx_pkg::TRIG_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int SHR_W   = SUM_W - rpx_pkg::FRAC_W;
	localparam int SF_IDX  = CORDIC_STEPS + 1;
	localparam int SM_IDX  = CORDIC_STEPS + 2;
	localparam int SO_IDX  = CORDIC_STEPS + 3;

	localparam logic signed [SUM_W-1:0] ROUND_HALF =
		SUM_W'(1) <<< (rpx_pkg::FRAC_W - 1);
	localparam logic signed [COORD_WIDTH-1:0] COORD_MAX =
		{1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] COORD_MIN =
		{1'b1, {(COORD_WIDTH-1){1'b0}}};

	function automatic logic signed [COORD_WIDTH-1:0] round_sat(
		input logic signed [SUM_W-1:0] sum
	);
		logic signed [SUM_W-1:0] biased;
		logic signed [SHR_W-1:0] q;
		biased = sum + ROUND_HALF;
		q = biased[SUM_W-1:rpx_pkg::FRAC_W];
		if (q[SHR_W-1:COORD_WIDTH-1] == {(SHR_W-COORD_WIDTH+1){1'b0}} ||
			q[SHR_W-1:COORD_WIDTH-1] == {(SHR_W-COORD_WIDTH+1){1'b1}}) begin
			return q[COORD_WIDTH-1:0];
		end else if (q[SHR_W-1]) begin
			return COORD_MIN;
		end else begin
			return COORD_MAX;
		end
	endfunction

	logic [NS-1:0] vld_q;
	logic [NS-1:0] adv;

	for (genvar k = 0; k < NS; k++) begin : g_adv
		assign adv[k] = result.ready || !(&vld_q[NS-1:k]);
	end

	assign point.ready  = adv[0];
	assign result.valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= point.valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	logic [rpx_pkg::PHASE_W-1:0]        phase_in;
	logic                               flip_in;
	logic signed [rpx_pkg::PHASE_W-1:0] res_in;

	assign phase_in = {point.turn_angle, {(rpx_pkg::PHASE_W-ANGLE_WIDTH){1'b0}}};
	assign flip_in  = phase_in[rpx_pkg::PHASE_W-1] ^ phase_in[rpx_pkg::PHASE_W-2];
	assign res_in   = {phase_in[rpx_pkg::PHASE_W-1] ^ flip_in,
		phase_in[rpx_pkg::PHASE_W-2:0]};

	logic signed [rpx_pkg::TRIG_W-1:0]  cos_c  [CORDIC_STEPS+1];
	logic signed [rpx_pkg::TRIG_W-1:0]  sin_c  [CORDIC_STEPS+1];
	logic signed [rpx_pkg::PHASE_W-1:0] res_c  [CORDIC_STEPS+1];
	logic [PASS_W-1:0]                  pass_c [CORDIC_STEPS+1];

	logic signed [rpx_pkg::PHASE_W-1:0] res_s1;
	logic [PASS_W-1:0]                  pass_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			res_s1  <= res_in;
			pass_s1 <= {flip_in, point.coord_x, point.coord_y, point.coord_z};
		end
	end

	assign cos_c[0]  = rpx_pkg::GAIN_Q30;
	assign sin_c[0]  = '0;
	assign res_c[0]  = res_s1;
	assign pass_c[0] = pass_s1;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		rpx_cordic_step #(
			.STEP   (i),
			.PASS_W (PASS_W)
		) u_step (
			.clk     (clk),
			.ld      (adv[i+1]),
			.cos_in  (cos_c[i]),
			.sin_in  (sin_c[i]),
			.res_in  (res_c[i]),
			.pass_in (pass_c[i]),
			.cos_s1  (cos_c[i+1]),
			.sin_s1  (sin_c[i+1]),
			.res_s1  (res_c[i+1]),
			.pass_s1 (pass_c[i+1])
		);
	end

	logic                              flip_c;
	logic signed [COORD_WIDTH-1:0]     x_c;
	logic signed [COORD_WIDTH-1:0]     y_c;
	logic signed [COORD_WIDTH-1:0]     z_c;

	assign flip_c = pass_c[CORDIC_STEPS][PASS_W-1];
	assign x_c    = pass_c[CORDIC_STEPS][3*COORD_WIDTH-1:2*COORD_WIDTH];
	assign y_c    = pass_c[CORDIC_STEPS][2*COORD_WIDTH-1:COORD_WIDTH];
	assign z_c    = pass_c[CORDIC_STEPS][COORD_WIDTH-1:0];

	logic signed [rpx_pkg::TRIG_W-1:0] cos_sf;
	logic signed [rpx_pkg::TRIG_W-1:0] sin_sf;
	logic signed [COORD_WIDTH-1:0]     x_sf;
	logic signed [COORD_WIDTH-1:0]     y_sf;
	logic signed [COORD_WIDTH-1:0]     z_sf;

	always_ff @(posedge clk) begin
		if (adv[SF_IDX]) begin
			cos_sf <= flip_c ? -cos_c[CORDIC_STEPS] : cos_c[CORDIC_STEPS];
			sin_sf <= flip_c ? -sin_c[CORDIC_STEPS] : sin_c[CORDIC_STEPS];
			x_sf   <= x_c;
			y_sf   <= y_c;
			z_sf   <= z_c;
		end
	end

	logic signed [PROD_W-1:0]      yc_sm;
	logic signed [PROD_W-1:0]      zs_sm;
	logic signed [PROD_W-1:0]      zc_sm;
	logic signed [PROD_W-1:0]      ys_sm;
	logic signed [COORD_WIDTH-1:0] x_sm;

	always_ff @(posedge clk) begin
		if (adv[SM_IDX]) begin
			yc_sm <= PROD_W'(y_sf) * PROD_W'(cos_sf);
			zs_sm <= PROD_W'(z_sf) * PROD_W'(sin_sf);
			zc_sm <= PROD_W'(z_sf) * PROD_W'(cos_sf);
			ys_sm <= PROD_W'(y_sf) * PROD_W'(sin_sf);
			x_sm  <= x_sf;
		end
	end

	logic signed [SUM_W-1:0]       sum_y;
	logic signed [SUM_W-1:0]       sum_z;
	logic signed [COORD_WIDTH-1:0] x_so;
	logic signed [COORD_WIDTH-1:0] y_so;
	logic signed [COORD_WIDTH-1:0] z_so;

	assign sum_y = SUM_W'(yc_sm) + SUM_W'(zs_sm);
	assign sum_z = SUM_W'(zc_sm) - SUM_W'(ys_sm);

	always_ff @(posedge clk) begin
		if (adv[SO_IDX]) begin
			x_so <= x_sm;
			y_so <= round_sat(sum_y);
			z_so <= round_sat(sum_z);
		end
	end

	assign result.rotated_x = x_so;
	assign result.rotated_y = y_so;
	assign result.rotated_z = z_so;

endmodule

// ----- rtl/rpx_cordic_step.sv -----
// One registered rotation-mode CORDIC iteration with its carried payload.
module rpx_cordic_step #(
	parameter int STEP   = 0,
	parameter int PASS_W = 1
) (
	input  logic                               clk,
	input  logic                               ld,
	input  logic signed [rpx_pkg::TRIG_W-1:0]  cos_in,
	input  logic signed [rpx_pkg::TRIG_W-1:0]  sin_in,
	input  logic signed [rpx_pkg::PHASE_W-1:0] res_in,
	input  logic [PASS_W-1:0]                  pass_in,
	output logic signed [rpx_pkg::TRIG_W-1:0]  cos_s1,
	output logic signed [rpx_pkg::TRIG_W-1:0]  sin_s1,
	output logic signed [rpx_pkg::PHASE_W-1:0] res_s1,
	output logic [PASS_W-1:0]                  pass_s1
);

	logic signed [rpx_pkg::TRIG_W-1:0]  cos_nx;
	logic signed [rpx_pkg::TRIG_W-1:0]  sin_nx;
	logic signed [rpx_pkg::PHASE_W-1:0] res_nx;
	logic signed [rpx_pkg::PHASE_W-1:0] angle_step;

	assign angle_step = $signed(rpx_pkg::ATAN_TAB[STEP]);

	always_comb begin
		if (!res_in[rpx_pkg::PHASE_W-1]) begin
			cos_nx = cos_in - (sin_in >>> STEP);
			sin_nx = sin_in + (cos_in >>> STEP);
			res_nx = res_in - angle_step;
		end else begin
			cos_nx = cos_in + (sin_in >>> STEP);
			sin_nx = sin_in - (cos_in >>> STEP);
			res_nx = res_in + angle_step;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			cos_s1  <= cos_nx;
			sin_s1  <= sin_nx;
			res_s1  <= res_nx;
			pass_s1 <= pass_in;
		end
	end

endmodule

// ----- rtl/rpx_checker.sv -----
// Port-level checks of the point rotation pipeline, bound to its top level.
module rpx_checker #(
	parameter int COORD_WIDTH = rpx_pkg::COORD_WIDTH_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [COORD_WIDTH-1:0] out_x,
	input logic [COORD_WIDTH-1:0] out_y,
	input logic [COORD_WIDTH-1:0] out_z
);

	// No item may come out while reset is held.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	// When the output stage can move, every stage can move, so the input is ready.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled while output stage can advance");

	// With the output full and stalled, an offered item is still taken if a bubble exists
	// is not checked here; only the output hold rules below.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z))
		else $error("result item changed under stall");

	// An input item stalled with the pipeline full means the output was stalled too.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |-> out_valid && !out_ready)
		else $error("input stalled without an output stall");

endmodule

bind rotate_point_about_x_axis rpx_checker #(
	.COORD_WIDTH (COORD_WIDTH)
) u_rpx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (point.valid),
	.in_ready  (point.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_x     (result.rotated_x),
	.out_y     (result.rotated_y),
	.out_z     (result.rotated_z)
);
